// ===== hdl/ppl_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and reset values for the Phong pixel lighting pipeline.
// No dependencies; every other source file depends on this package.
package ppl_pkg;

   // Item and register field widths
   localparam int POS_W      = 32;
   localparam int NRM_W      = 16;
   localparam int COL_W      = 8;
   localparam int AMB_W      = 16;
   localparam int POW_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_X   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Y   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_Z   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AMBIENT = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER   = 3'd7;

   localparam logic [AMB_W-1:0] AMB_RST = 16'd1638;
   localparam logic [POW_W-1:0] POW_RST = 7'd30;

   // Unit vector unit
   localparam int MAG_W      = POS_W + 1;
   localparam int TOP_W      = $clog2(MAG_W);
   localparam int MN_W       = 30;
   localparam int SQ_W       = 2 * MN_W;
   localparam int ROOT_W     = 64;
   localparam int SQRT_STEPS = ROOT_W / 2;
   localparam int LEN_W      = MN_W + 1;
   localparam int UV_FRAC    = 14;
   localparam int Q_W        = UV_FRAC + 1;
   localparam int DIV_STEPS  = Q_W;
   localparam int D_W        = MN_W + UV_FRAC + 1;
   localparam int UV_W       = 16;
   localparam int UV_LAT     = 3 + (SQRT_STEPS + 1) + (DIV_STEPS + 1) + 1;

   // Specular power chain
   localparam int ACC_W     = 17;
   localparam int RND_SH    = 16;
   localparam int POW_STEPS = (1 << POW_W) - 1;
   localparam logic [ACC_W-1:0] ONE_Q16 = 17'h10000;

endpackage

// ===== hdl/ppl_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the lighting pipeline: fragment request and lit response.
// Depends on ppl_pkg for field widths.
interface ppl_req_if;
   logic valid;
   logic ready;
   logic signed [ppl_pkg::POS_W-1:0] pos_x;
   logic signed [ppl_pkg::POS_W-1:0] pos_y;
   logic signed [ppl_pkg::POS_W-1:0] pos_z;
   logic signed [ppl_pkg::NRM_W-1:0] norm_x;
   logic signed [ppl_pkg::NRM_W-1:0] norm_y;
   logic signed [ppl_pkg::NRM_W-1:0] norm_z;
   logic [ppl_pkg::COL_W-1:0] mat_red;
   logic [ppl_pkg::COL_W-1:0] mat_green;
   logic [ppl_pkg::COL_W-1:0] mat_blue;
   logic [ppl_pkg::COL_W-1:0] mat_alpha;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   mat_red, mat_green, mat_blue, mat_alpha, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 mat_red, mat_green, mat_blue, mat_alpha, output ready);
endinterface

interface ppl_rsp_if;
   logic valid;
   logic ready;
   logic [ppl_pkg::COL_W-1:0] out_red;
   logic [ppl_pkg::COL_W-1:0] out_green;
   logic [ppl_pkg::COL_W-1:0] out_blue;
   logic [ppl_pkg::COL_W-1:0] out_alpha;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

// ===== hdl/ppl_unit_vec.sv =====
`timescale 1ns / 1ps
// Pipelined Q2.14 unit vector from point to target: scale, square root, per-lane divide.
// Depends on ppl_pkg; advances when adv is high.
module ppl_unit_vec (
   input  logic clock,
   input  logic adv,
   input  logic [2:0][ppl_pkg::POS_W-1:0] tgt,
   input  logic [2:0][ppl_pkg::POS_W-1:0] pnt,
   output logic [2:0][ppl_pkg::UV_W-1:0] uvec
);
   import ppl_pkg::*;

   typedef struct packed {
      logic [ROOT_W-1:0]        v;
      logic [ROOT_W-1:0]        res;
      logic [2:0][MN_W-1:0]     m;
      logic [2:0]               neg;
      logic                     zero;
   } sqrt_stage_type;

   typedef struct packed {
      logic [2:0][D_W-1:0]      r;
      logic [2:0][Q_W-1:0]      q;
      logic [LEN_W-1:0]         len;
      logic [2:0]               neg;
      logic                     zero;
   } div_stage_type;

   // Stage 0: differences and magnitudes
   logic [2:0][MAG_W-1:0] mag_in, mag_ff;
   logic [2:0]            neg_in, neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [MAG_W-1:0] d;
         d = $signed({tgt[i][POS_W-1], tgt[i]}) - $signed({pnt[i][POS_W-1], pnt[i]});
         neg_in[i] = d[MAG_W-1];
         mag_in[i] = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // Stage 1: put the largest magnitude's top bit at MN_W-1
   logic [MAG_W-1:0]      mx;
   logic [TOP_W-1:0]      top;
   logic [2:0][MN_W-1:0]  m1_in, m1_ff;
   logic [2:0]            neg1_ff;
   logic                  zero1_ff;

   always_comb begin
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
      top = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (mx[b]) top = TOP_W'(b);
      end
      for (int i = 0; i < 3; i++) begin
         m1_in[i] = MN_W'({mag_ff[i], {(MN_W-1){1'b0}}} >> top);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff    <= m1_in;
         neg1_ff  <= neg_ff;
         zero1_ff <= (mx == '0);
      end
   end

   // Stage 2: squares
   logic [2:0][SQ_W-1:0]  sq2_ff;
   logic [2:0][MN_W-1:0]  m2_ff;
   logic [2:0]            neg2_ff;
   logic                  zero2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= SQ_W'(m1_ff[i]) * SQ_W'(m1_ff[i]);
         end
         m2_ff    <= m1_ff;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
      end
   end

   // Square root, one result bit per stage
   sqrt_stage_type sqrt_ff [SQRT_STEPS+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sqrt_ff[0].v    <= ROOT_W'(sq2_ff[0]) + ROOT_W'(sq2_ff[1]) + ROOT_W'(sq2_ff[2]);
         sqrt_ff[0].res  <= '0;
         sqrt_ff[0].m    <= m2_ff;
         sqrt_ff[0].neg  <= neg2_ff;
         sqrt_ff[0].zero <= zero2_ff;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (ROOT_W - 2 - 2 * k);
      sqrt_stage_type    st_in;
      logic [ROOT_W-1:0] trial;

      always_comb begin
         trial = sqrt_ff[k].res + BIT;
         st_in = sqrt_ff[k];
         if (sqrt_ff[k].v >= trial) begin
            st_in.v   = sqrt_ff[k].v - trial;
            st_in.res = (sqrt_ff[k].res >> 1) + BIT;
         end else begin
            st_in.res = sqrt_ff[k].res >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) sqrt_ff[k+1] <= st_in;
      end
   end

   // Divide: rounded numerator, then one quotient bit per stage
   div_stage_type    div_ff [DIV_STEPS+1];
   logic [LEN_W-1:0] len;

   assign len = sqrt_ff[SQRT_STEPS].res[LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            div_ff[0].r[i] <= (D_W'(sqrt_ff[SQRT_STEPS].m[i]) << UV_FRAC) + D_W'(len >> 1);
         end
         div_ff[0].q    <= '0;
         div_ff[0].len  <= len;
         div_ff[0].neg  <= sqrt_ff[SQRT_STEPS].neg;
         div_ff[0].zero <= sqrt_ff[SQRT_STEPS].zero;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int KB = DIV_STEPS - 1 - j;
      div_stage_type dv_in;
      logic [D_W-1:0] dsh;

      always_comb begin
         dsh   = D_W'(div_ff[j].len) << KB;
         dv_in = div_ff[j];
         for (int i = 0; i < 3; i++) begin
            if (div_ff[j].r[i] >= dsh) begin
               dv_in.r[i]     = div_ff[j].r[i] - dsh;
               dv_in.q[i][KB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) div_ff[j+1] <= dv_in;
      end
   end

   // Output: sign and zero vector
   logic [2:0][UV_W-1:0] uvec_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (div_ff[DIV_STEPS].zero) begin
               uvec_ff[i] <= '0;
            end else if (div_ff[DIV_STEPS].neg[i]) begin
               uvec_ff[i] <= UV_W'(-UV_W'(div_ff[DIV_STEPS].q[i]));
            end else begin
               uvec_ff[i] <= UV_W'(div_ff[DIV_STEPS].q[i]);
            end
         end
      end
   end

   assign uvec = uvec_ff;

endmodule

// ===== hdl/phong_pixel_lighting.sv =====
`timescale 1ns / 1ps
// Phong per-pixel lighting top level: config registers, unit vectors, dots, power chain.
// Depends on ppl_pkg, ppl_if and ppl_unit_vec.
//
// Takes one fragment per clock while the response is not stalled, and returns one lit pixel per
// fragment, in order. The pipeline depth lies mostly in the unit vectors, chiefly their square
// root and divide, and in the specular power chain, one multiplier stage per possible exponent
// step. A stalled response freezes the whole pipeline; nothing is dropped. Config registers are
// written through the csr port and must only change while no item is in flight.
module phong_pixel_lighting (
   input  logic clock,
   input  logic reset,
   ppl_req_if.sink   req_ch,
   ppl_rsp_if.source rsp_ch,
   input  logic csr_wr_en,
   input  logic [ppl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppl_pkg::*;

   localparam int NLP_W  = NRM_W + UV_W;
   localparam int NL_W   = NLP_W + 2;
   localparam int NLQ_W  = NL_W - UV_FRAC;
   localparam int TP_W   = NLQ_W + NRM_W;
   localparam int RV_W   = TP_W - UV_FRAC + 2;
   localparam int REP_W  = RV_W + UV_W;
   localparam int RE_W   = REP_W + 2;
   localparam int DSH    = 12;
   localparam int DIFF_W = 19;
   localparam int RSH_W  = RE_W - DSH;
   localparam int AMBP_W = COL_W + AMB_W;
   localparam int DIFP_W = COL_W + DIFF_W;
   localparam int SPC_W  = COL_W + ACC_W;
   localparam int SUM_W  = AMBP_W + 5;
   localparam logic signed [UV_W-1:0] UV_ONE = 16'sd16384;

   typedef struct packed {
      logic                    valid;
      logic [2:0][NRM_W-1:0]   nrm;
      logic [2:0][COL_W-1:0]   mat;
      logic [COL_W-1:0]        alpha;
   } side_type;

   typedef struct packed {
      logic                    valid;
      logic [2:0][NRM_W-1:0]   nrm;
      logic [2:0][UV_W-1:0]    lv;
      logic [2:0][UV_W-1:0]    ev;
      logic [2:0][COL_W-1:0]   mat;
      logic [COL_W-1:0]        alpha;
   } carry_type;

   typedef struct packed {
      logic                    valid;
      logic [DIFF_W-1:0]       diff;
      logic [2:0][COL_W-1:0]   mat;
      logic [COL_W-1:0]        alpha;
      logic [ACC_W-1:0]        base;
      logic                    en;
      logic [ACC_W-1:0]        acc;
   } pow_stage_type;

   typedef struct packed {
      logic                    valid;
      logic [COL_W-1:0]        alpha;
      logic [2:0][AMBP_W-1:0]  ambp;
      logic [2:0][DIFP_W-1:0]  difp;
      logic [SPC_W-1:0]        spc;
   } fin_type;

   // Config registers
   logic [2:0][POS_W-1:0] light_ff, eye_ff;
   logic [AMB_W-1:0]      amb_ff;
   logic [POW_W-1:0]      power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff <= '0;
         eye_ff   <= '0;
         amb_ff   <= AMB_RST;
         power_ff <= POW_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LIGHT_X: light_ff[0] <= csr_wdata;
            CSR_LIGHT_Y: light_ff[1] <= csr_wdata;
            CSR_LIGHT_Z: light_ff[2] <= csr_wdata;
            CSR_EYE_X:   eye_ff[0]   <= csr_wdata;
            CSR_EYE_Y:   eye_ff[1]   <= csr_wdata;
            CSR_EYE_Z:   eye_ff[2]   <= csr_wdata;
            CSR_AMBIENT: amb_ff      <= csr_wdata[AMB_W-1:0];
            CSR_POWER:   power_ff    <= csr_wdata[POW_W-1:0];
         endcase
      end
   end

   // Global advance: the output register is free or being taken
   logic rsp_valid_ff;
   logic adv;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Unit vectors toward light and eye
   logic [2:0][POS_W-1:0] pos_vec;
   logic [2:0][UV_W-1:0]  lv, ev;

   assign pos_vec = {req_ch.pos_z, req_ch.pos_y, req_ch.pos_x};

   ppl_unit_vec u_light (
      .clock (clock),
      .adv   (adv),
      .tgt   (light_ff),
      .pnt   (pos_vec),
      .uvec  (lv)
   );

   ppl_unit_vec u_eye (
      .clock (clock),
      .adv   (adv),
      .tgt   (eye_ff),
      .pnt   (pos_vec),
      .uvec  (ev)
   );

   // Side data delay line, aligned with the unit vector outputs
   side_type sb_ff [UV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         sb_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sb_ff[0].valid <= req_ch.valid;
         sb_ff[0].nrm   <= {req_ch.norm_z, req_ch.norm_y, req_ch.norm_x};
         sb_ff[0].mat   <= {req_ch.mat_blue, req_ch.mat_green, req_ch.mat_red};
         sb_ff[0].alpha <= req_ch.mat_alpha;
      end
   end

   for (genvar k = 1; k < UV_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) sb_ff[k].valid <= 1'b0;
         else if (adv) sb_ff[k] <= sb_ff[k-1];
      end
   end

   // P0: N.L products
   carry_type               c0_ff, c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [NLP_W-1:0] np0_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff.valid <= 1'b0;
      end else if (adv) begin
         c0_ff.valid <= sb_ff[UV_LAT-1].valid;
         c0_ff.nrm   <= sb_ff[UV_LAT-1].nrm;
         c0_ff.mat   <= sb_ff[UV_LAT-1].mat;
         c0_ff.alpha <= sb_ff[UV_LAT-1].alpha;
         c0_ff.lv    <= lv;
         c0_ff.ev    <= ev;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            np0_ff[i] <= $signed(sb_ff[UV_LAT-1].nrm[i]) * $signed(lv[i]);
         end
      end
   end

   // P1: N.L sum
   logic signed [NL_W-1:0] nl1_ff;

   always_ff @(posedge clock) begin
      if (reset) c1_ff.valid <= 1'b0;
      else if (adv) c1_ff <= c0_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) nl1_ff <= NL_W'(np0_ff[0]) + NL_W'(np0_ff[1]) + NL_W'(np0_ff[2]);
   end

   // P2: diffuse factor and floor(N.L) * N
   logic signed [NLQ_W-1:0] nlq;
   logic [DIFF_W-1:0]       diff2_ff, diff3_ff, diff4_ff;
   logic signed [TP_W-1:0]  tp2_ff [3];

   assign nlq = $signed(nl1_ff[NL_W-1:UV_FRAC]);

   always_ff @(posedge clock) begin
      if (reset) c2_ff.valid <= 1'b0;
      else if (adv) c2_ff <= c1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff2_ff <= (nl1_ff > 0) ? nl1_ff[DIFF_W+DSH-1:DSH] : '0;
         for (int i = 0; i < 3; i++) begin
            tp2_ff[i] <= nlq * $signed(c1_ff.nrm[i]);
         end
      end
   end

   // P3: reflected vector R = -L + 2 floor(N.L) N
   logic signed [RV_W-1:0] rv3_ff [3];

   always_ff @(posedge clock) begin
      if (reset) c3_ff.valid <= 1'b0;
      else if (adv) c3_ff <= c2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff3_ff <= diff2_ff;
         for (int i = 0; i < 3; i++) begin
            rv3_ff[i] <= RV_W'($signed(tp2_ff[i][TP_W-1:UV_FRAC-1]))
                       - RV_W'($signed(c2_ff.lv[i]));
         end
      end
   end

   // P4: R.E products
   logic signed [REP_W-1:0] rep4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) c4_ff.valid <= 1'b0;
      else if (adv) c4_ff <= c3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff4_ff <= diff3_ff;
         for (int i = 0; i < 3; i++) begin
            rep4_ff[i] <= rv3_ff[i] * $signed(c3_ff.ev[i]);
         end
      end
   end

   // P5: R.E sum, clamp the base to one
   logic signed [RE_W-1:0] re;
   logic [RSH_W-1:0]       rsh;
   logic [ACC_W-1:0]       base;
   pow_stage_type          pow_ff [POW_STEPS+1];

   always_comb begin
      re   = RE_W'(rep4_ff[0]) + RE_W'(rep4_ff[1]) + RE_W'(rep4_ff[2]);
      rsh  = re[RE_W-1:DSH];
      base = (rsh > RSH_W'(ONE_Q16)) ? ONE_Q16 : rsh[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pow_ff[0].valid <= 1'b0;
      end else if (adv) begin
         pow_ff[0].valid <= c4_ff.valid;
         pow_ff[0].diff  <= diff4_ff;
         pow_ff[0].mat   <= c4_ff.mat;
         pow_ff[0].alpha <= c4_ff.alpha;
         pow_ff[0].base  <= base;
         pow_ff[0].en    <= (re > 0) && (power_ff != '0);
         pow_ff[0].acc   <= ONE_Q16;
      end
   end

   // Power chain: step k applies the base while k is below the exponent
   for (genvar k = 0; k < POW_STEPS; k++) begin : g_pow
      pow_stage_type        pw_in;
      logic [2*ACC_W-1:0]   pr;

      always_comb begin
         pr    = (2*ACC_W)'(pow_ff[k].acc) * (2*ACC_W)'(pow_ff[k].base)
               + (2*ACC_W)'(1 << (RND_SH - 1));
         pw_in = pow_ff[k];
         if (POW_W'(k) < power_ff) pw_in.acc = pr[RND_SH+ACC_W-1:RND_SH];
      end

      always_ff @(posedge clock) begin
         if (reset) pow_ff[k+1].valid <= 1'b0;
         else if (adv) pow_ff[k+1] <= pw_in;
      end
   end

   // F0: per-channel terms
   fin_type          fin_ff;
   logic [ACC_W-1:0] spec;

   assign spec = pow_ff[POW_STEPS].en ? pow_ff[POW_STEPS].acc : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.valid <= 1'b0;
      end else if (adv) begin
         fin_ff.valid <= pow_ff[POW_STEPS].valid;
         fin_ff.alpha <= pow_ff[POW_STEPS].alpha;
         fin_ff.spc   <= SPC_W'(spec) * SPC_W'(8'd255);
         for (int i = 0; i < 3; i++) begin
            fin_ff.ambp[i] <= AMBP_W'(pow_ff[POW_STEPS].mat[i]) * AMBP_W'(amb_ff);
            fin_ff.difp[i] <= DIFP_W'(pow_ff[POW_STEPS].mat[i])
                            * DIFP_W'(pow_ff[POW_STEPS].diff);
         end
      end
   end

   // F1: round, saturate, output register
   logic [2:0][COL_W-1:0] col_in, col_ff;
   logic [COL_W-1:0]      alpha_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic [SUM_W-1:0]        sum;
         logic [SUM_W-RND_SH-1:0] c;
         sum = SUM_W'(fin_ff.ambp[i]) + SUM_W'(fin_ff.difp[i]) + SUM_W'(fin_ff.spc)
             + SUM_W'(1 << (RND_SH - 1));
         c   = sum[SUM_W-1:RND_SH];
         col_in[i] = (c > (SUM_W-RND_SH)'(8'd255)) ? 8'd255 : c[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= fin_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff   <= col_in;
         alpha_ff <= fin_ff.alpha;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_red   = col_ff[0];
   assign rsp_ch.out_green = col_ff[1];
   assign rsp_ch.out_blue  = col_ff[2];
   assign rsp_ch.out_alpha = alpha_ff;

   // Checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("response valid after reset");

   a_stall_only_on_block: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("input held off without an output stall");

   a_light_unit: assert property (@(posedge clock) disable iff (reset)
      c0_ff.valid |->
         ($signed(c0_ff.lv[0]) <= UV_ONE) && ($signed(c0_ff.lv[0]) >= -UV_ONE) &&
         ($signed(c0_ff.lv[1]) <= UV_ONE) && ($signed(c0_ff.lv[1]) >= -UV_ONE) &&
         ($signed(c0_ff.lv[2]) <= UV_ONE) && ($signed(c0_ff.lv[2]) >= -UV_ONE))
      else $error("light unit vector component out of range");

   a_power_bound: assert property (@(posedge clock) disable iff (reset)
      pow_ff[POW_STEPS].valid |-> (pow_ff[POW_STEPS].acc <= ONE_Q16))
      else $error("specular power above one");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for phong_pixel_lighting: random and directed fragments under idle and stall phases.
// Depends on ppl_pkg, ppl_if and the lighting pipeline RTL.
module tb;
   import ppl_pkg::*;

   localparam int LIMIT = 600000;

   typedef longint vec3_type [3];

   typedef struct {
      logic signed [POS_W-1:0] px, py, pz;
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic [COL_W-1:0] r, g, b, a;
   } frag_type;

   typedef struct {
      logic [COL_W-1:0] r, g, b, a;
   } pixel_type;

   class shade_scoreboard;
      longint light [3];
      longint eye [3];
      longint unsigned ambient;
      int unsigned power;
      pixel_type lit_q [$];
      int errors;

      function new();
         light = '{0, 0, 0};
         eye = '{0, 0, 0};
         ambient = AMB_RST;
         power = POW_RST;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LIGHT_X: light[0] = longint'($signed(val));
            CSR_LIGHT_Y: light[1] = longint'($signed(val));
            CSR_LIGHT_Z: light[2] = longint'($signed(val));
            CSR_EYE_X: eye[0] = longint'($signed(val));
            CSR_EYE_Y: eye[1] = longint'($signed(val));
            CSR_EYE_Z: eye[2] = longint'($signed(val));
            CSR_AMBIENT: ambient = val[AMB_W-1:0];
            CSR_POWER: power = val[POW_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned res, bt;
         res = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt >>= 2;
         while (bt != 0) begin
            if (v >= res + bt) begin
               v -= res + bt;
               res = (res >> 1) + bt;
            end else begin
               res >>= 1;
            end
            bt >>= 2;
         end
         return res;
      endfunction

      // Q2.14 unit vector; zero in gives zero out
      function vec3_type unit_dir(vec3_type d);
         longint unsigned m [3];
         longint unsigned mx, ls, len, q;
         int top;
         vec3_type u;
         mx = 0;
         ls = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = (d[i] < 0) ? -d[i] : d[i];
            if (m[i] > mx) mx = m[i];
         end
         if (mx == 0) return '{0, 0, 0};
         top = 0;
         while (top < 63 && (mx >> (top + 1)) != 0) top++;
         for (int i = 0; i < 3; i++) begin
            if (top > 29) m[i] >>= (top - 29);
            else m[i] <<= (29 - top);
            ls += m[i] * m[i];
         end
         len = root(ls);
         for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
         end
         return u;
      endfunction

      function pixel_type shade(frag_type f);
         vec3_type p, n, dl, de, lv, ev, rv;
         longint nl, nlq, re;
         longint unsigned mat [3];
         longint unsigned diff, spec, base, acc, sum, c;
         logic [COL_W-1:0] ch [3];
         pixel_type o;
         p = '{f.px, f.py, f.pz};
         n = '{f.nx, f.ny, f.nz};
         mat = '{f.r, f.g, f.b};
         for (int i = 0; i < 3; i++) begin
            dl[i] = light[i] - p[i];
            de[i] = eye[i] - p[i];
         end
         lv = unit_dir(dl);
         ev = unit_dir(de);
         nl = n[0] * lv[0] + n[1] * lv[1] + n[2] * lv[2];
         diff = (nl > 0) ? longint'(nl) >>> 12 : 0;
         spec = 0;
         if (power != 0) begin
            nlq = nl >>> 14;
            for (int i = 0; i < 3; i++) rv[i] = -lv[i] + ((2 * nlq * n[i]) >>> 14);
            re = rv[0] * ev[0] + rv[1] * ev[1] + rv[2] * ev[2];
            if (re > 0) begin
               base = re >>> 12;
               if (base > 65536) base = 65536;
               acc = 65536;
               for (int i = 0; i < power; i++) acc = (acc * base + 32768) >> 16;
               spec = acc;
            end
         end
         for (int i = 0; i < 3; i++) begin
            sum = mat[i] * ambient + mat[i] * diff + 255 * spec;
            c = (sum + 32768) >> 16;
            ch[i] = (c > 255) ? 8'd255 : c[7:0];
         end
         o.r = ch[0];
         o.g = ch[1];
         o.b = ch[2];
         o.a = f.a;
         return o;
      endfunction

      function void note_fragment(frag_type f);
         lit_q.push_back(shade(f));
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (lit_q.size() == 0) begin
            $error("pixel with no fragment pending");
            errors++;
            return;
         end
         want = lit_q.pop_front();
         if (got.r !== want.r) begin
            $error("out_red expected %0d actual %0d", want.r, got.r);
            errors++;
         end
         if (got.g !== want.g) begin
            $error("out_green expected %0d actual %0d", want.g, got.g);
            errors++;
         end
         if (got.b !== want.b) begin
            $error("out_blue expected %0d actual %0d", want.b, got.b);
            errors++;
         end
         if (got.a !== want.a) begin
            $error("out_alpha expected %0d actual %0d", want.a, got.a);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   ppl_req_if req_ch ();
   ppl_rsp_if rsp_ch ();

   shade_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   logic hold_go = 0;
   logic rsp_hold = 0;
   int cycles = 0;

   phong_pixel_lighting dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.pos_x = 0;
      req_ch.pos_y = 0;
      req_ch.pos_z = 0;
      req_ch.norm_x = 0;
      req_ch.norm_y = 0;
      req_ch.norm_z = 0;
      req_ch.mat_red = 0;
      req_ch.mat_green = 0;
      req_ch.mat_blue = 0;
      req_ch.mat_alpha = 0;
      rsp_ch.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 0;
      else rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go <= 0;
            rsp_hold <= 1;
            repeat (400) @(posedge clock);
            rsp_hold <= 0;
         end
      end
   end

   always @(posedge clock) begin
      frag_type f;
      pixel_type p;
      if (!reset && req_ch.valid && req_ch.ready) begin
         f.px = req_ch.pos_x;
         f.py = req_ch.pos_y;
         f.pz = req_ch.pos_z;
         f.nx = req_ch.norm_x;
         f.ny = req_ch.norm_y;
         f.nz = req_ch.norm_z;
         f.r = req_ch.mat_red;
         f.g = req_ch.mat_green;
         f.b = req_ch.mat_blue;
         f.a = req_ch.mat_alpha;
         sb.note_fragment(f);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         p.r = rsp_ch.out_red;
         p.g = rsp_ch.out_green;
         p.b = rsp_ch.out_blue;
         p.a = rsp_ch.out_alpha;
         sb.check_pixel(p);
      end
   end

   task automatic send_fragment(frag_type f);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.pos_x <= f.px;
      req_ch.pos_y <= f.py;
      req_ch.pos_z <= f.pz;
      req_ch.norm_x <= f.nx;
      req_ch.norm_y <= f.ny;
      req_ch.norm_z <= f.nz;
      req_ch.mat_red <= f.r;
      req_ch.mat_green <= f.g;
      req_ch.mat_blue <= f.b;
      req_ch.mat_alpha <= f.a;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (sb.lit_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(vec3_type lp, vec3_type ep, int unsigned amb, int unsigned pw);
      logic [CSR_DATA_W-1:0] vals [8];
      vals = '{CSR_DATA_W'(lp[0]), CSR_DATA_W'(lp[1]), CSR_DATA_W'(lp[2]),
               CSR_DATA_W'(ep[0]), CSR_DATA_W'(ep[1]), CSR_DATA_W'(ep[2]), amb, pw};
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1;
         csr_index <= i[CSR_IDX_W-1:0];
         csr_wdata <= vals[i];
         sb.set_reg(i[CSR_IDX_W-1:0], vals[i]);
         @(posedge clock);
      end
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic frag_type make_frag(longint x, longint y, longint z, int nx, int ny,
                                          int nz, int r, int g, int b, int a);
      frag_type f;
      f.px = POS_W'(x);
      f.py = POS_W'(y);
      f.pz = POS_W'(z);
      f.nx = NRM_W'(nx);
      f.ny = NRM_W'(ny);
      f.nz = NRM_W'(nz);
      f.r = COL_W'(r);
      f.g = COL_W'(g);
      f.b = COL_W'(b);
      f.a = COL_W'(a);
      return f;
   endfunction

   function automatic int near_coord();
      return int'($urandom_range(2097152)) - 1048576;
   endfunction

   // Mostly sane fragments near the scene, some raw noise, some sitting on light or eye
   function automatic frag_type rand_frag();
      frag_type f;
      int sel;
      int len;
      sel = $urandom_range(99);
      f.r = COL_W'($urandom);
      f.g = COL_W'($urandom);
      f.b = COL_W'($urandom);
      f.a = COL_W'($urandom);
      if (sel < 15) begin
         f.px = $urandom;
         f.py = $urandom;
         f.pz = $urandom;
         f.nx = NRM_W'($urandom);
         f.ny = NRM_W'($urandom);
         f.nz = NRM_W'($urandom);
      end else begin
         f.px = near_coord();
         f.py = near_coord();
         f.pz = near_coord();
         len = (sel < 30) ? 32767 : 16384;
         f.nx = NRM_W'(int'($urandom_range(2 * len)) - len);
         f.ny = NRM_W'(int'($urandom_range(2 * len)) - len);
         f.nz = NRM_W'(int'($urandom_range(2 * len)) - len);
         if (sel < 20) begin
            f.px = POS_W'(sb.light[0]);
            f.py = POS_W'(sb.light[1]);
            f.pz = POS_W'(sb.light[2]);
         end else if (sel < 24) begin
            f.px = POS_W'(sb.eye[0]);
            f.py = POS_W'(sb.eye[1]);
            f.pz = POS_W'(sb.eye[2]);
         end
      end
      return f;
   endfunction

   initial begin
      vec3_type lp, ep;
      int unsigned amb, pw;
      frag_type dirs [$];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: reset settings, light and eye at origin
      dirs.push_back(make_frag(0, 0, 0, 16384, 0, 0, 255, 255, 255, 255));
      dirs.push_back(make_frag(65536, 0, 0, 16384, 0, 0, 255, 128, 0, 0));
      dirs.push_back(make_frag(-65536, 0, 0, 16384, 0, 0, 255, 255, 255, 7));
      dirs.push_back(make_frag(0, -65536, 0, 0, 16384, 0, 0, 0, 0, 200));
      dirs.push_back(make_frag(0, 0, -65536, 0, 0, -16384, 100, 200, 50, 1));
      dirs.push_back(make_frag(0, 0, -65536, 0, 0, 0, 255, 255, 255, 3));
      dirs.push_back(make_frag(-2147483648, -2147483648, -2147483648, -32768, -32768, -32768,
                               255, 255, 255, 255));
      dirs.push_back(make_frag(2147483647, 2147483647, 2147483647, 32767, 32767, 32767,
                               0, 0, 0, 0));
      dirs.push_back(make_frag(-2147483648, 2147483647, 0, 32767, -32768, 0, 1, 254, 128, 127));
      dirs.push_back(make_frag(-65536, -65536, -65536, 9459, 9459, 9459, 40, 80, 160, 128));
      foreach (dirs[i]) send_fragment(dirs[i]);
      drain();

      // Directed: light behind the surface but reflection toward the eye
      write_regs('{0, 0, -655360}, '{0, 0, -655360}, AMB_RST, 64);
      dirs.delete();
      dirs.push_back(make_frag(0, 0, 0, 0, 0, 16384, 200, 100, 50, 9));
      dirs.push_back(make_frag(0, 0, 0, 0, 0, -16384, 200, 100, 50, 9));
      dirs.push_back(make_frag(0, 0, 0, 0, 0, 32767, 255, 255, 255, 9));
      dirs.push_back(make_frag(0, 0, -655360, 0, 0, -16384, 255, 255, 255, 9));
      dirs.push_back(make_frag(65536, 0, -655360, 0, 0, -16384, 10, 20, 30, 9));
      foreach (dirs[i]) send_fragment(dirs[i]);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 86; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 86; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         case (ph)
            0: begin
               lp = '{near_coord(), near_coord(), near_coord()};
               ep = '{near_coord(), near_coord(), near_coord()};
               amb = $urandom_range(65535);
               pw = $urandom_range(64);
            end
            1: begin
               lp = '{2147483647, -2147483648, 2147483647};
               ep = '{-2147483648, 2147483647, -2147483648};
               amb = 65535;
               pw = 64;
            end
            2: begin
               lp = '{near_coord(), near_coord(), near_coord()};
               ep = '{near_coord(), near_coord(), near_coord()};
               amb = 0;
               pw = 0;
            end
            3: begin
               lp = '{0, 0, 4 * 65536};
               ep = '{0, 0, 4 * 65536};
               amb = 8192;
               pw = 1;
            end
            4: begin
               lp = '{near_coord(), near_coord(), near_coord()};
               ep = lp;
               amb = $urandom_range(65535);
               pw = 127;
            end
            default: begin
               lp = '{int'($urandom), int'($urandom), near_coord()};
               ep = '{near_coord(), near_coord(), near_coord()};
               amb = $urandom_range(65535);
               pw = $urandom_range(127);
            end
         endcase
         write_regs(lp, ep, amb, pw);
         for (int k = 0; k < 235; k++) begin
            // fill the pipeline against a long receiver hold
            if (ph == 0 && k == 20) hold_go <= 1;
            send_fragment(rand_frag());
         end
         drain();
      end

      while (sb.lit_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== phong_pixel_lighting.f =====
hdl/ppl_pkg.sv
hdl/ppl_if.sv
hdl/ppl_unit_vec.sv
hdl/phong_pixel_lighting.sv
tb/tb.sv
